FILE: src/dlfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlfp_pkg
// Types, codes and constants shared by the chat frame byte tagger.
// ----------------------------------------------------------------------------
package dlfp_pkg;

   // parse phases
   localparam logic [3:0] PH_WAIT      = 4'd0;
   localparam logic [3:0] PH_SNDLEN    = 4'd1;
   localparam logic [3:0] PH_SENDER    = 4'd2;
   localparam logic [3:0] PH_MSGLEN    = 4'd3;
   localparam logic [3:0] PH_MESSAGE   = 4'd4;
   localparam logic [3:0] PH_ERRTEXT   = 4'd5;
   localparam logic [3:0] PH_USERCOUNT = 4'd6;
   localparam logic [3:0] PH_NAMELEN   = 4'd7;
   localparam logic [3:0] PH_NAME      = 4'd8;

   // byte kinds
   localparam logic [2:0] KIND_TYPE    = 3'd0;
   localparam logic [2:0] KIND_DIGIT   = 3'd1;
   localparam logic [2:0] KIND_SENDER  = 3'd2;
   localparam logic [2:0] KIND_MESSAGE = 3'd3;
   localparam logic [2:0] KIND_ERRTEXT = 3'd4;
   localparam logic [2:0] KIND_NAME    = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN = 3'd6;
   localparam logic [2:0] KIND_BADDIG  = 3'd7;

   // frame type codes
   localparam logic [1:0] FRAME_PRIVATE   = 2'd0;
   localparam logic [1:0] FRAME_BROADCAST = 2'd1;
   localparam logic [1:0] FRAME_ERROR     = 2'd2;
   localparam logic [1:0] FRAME_USERLIST  = 2'd3;

   // type bytes and digits
   localparam logic [7:0] CHAR_PRIVATE   = 8'h54;  // 'T'
   localparam logic [7:0] CHAR_BROADCAST = 8'h4D;  // 'M'
   localparam logic [7:0] CHAR_ERROR     = 8'h45;  // 'E'
   localparam logic [7:0] CHAR_USERLIST  = 8'h4C;  // 'L'
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   localparam logic [1:0] MSG_LEN_DIGITS   = 2'd3;
   localparam logic [1:0] SHORT_LEN_DIGITS = 2'd2;
   localparam logic [7:0] ERROR_LEN_RESET  = 8'd15;

   typedef struct packed {
      logic [3:0] parse_phase;
      logic [1:0] digit_count;
      logic [9:0] length_accum;
      logic [9:0] bytes_left;
      logic [1:0] frame_code;
      logic [6:0] users_left;
   } state_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic [2:0] byte_kind;
      logic [1:0] frame_type;
      logic       field_last;
      logic       frame_end;
   } result_type;

endpackage
`default_nettype wire

FILE: src/dlfp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlfp_step
// Tags one byte against the current parse state and computes the next state.
// ----------------------------------------------------------------------------
module dlfp_step (
   input  wire logic [7:0]          rx_byte,
   input  wire logic [7:0]          error_text_length,
   input  wire dlfp_pkg::state_type state_cur,
   output dlfp_pkg::state_type      state_nxt,
   output dlfp_pkg::result_type     result
);
   import dlfp_pkg::*;

   logic       is_digit;
   logic [1:0] digits_needed;
   logic [1:0] count_inc;
   logic [9:0] accum_inc;
   logic [9:0] left_dec;
   logic [6:0] users_dec;
   logic [6:0] users_from_count;
   logic [2:0] kind;
   logic [1:0] ftype;
   logic       flast;
   logic       fend;

   assign is_digit      = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign digits_needed = (state_cur.parse_phase == PH_MSGLEN) ? MSG_LEN_DIGITS
                                                               : SHORT_LEN_DIGITS;
   assign count_inc     = state_cur.digit_count + 2'd1;
   // acc*10 + digit, kept to 10 bits
   assign accum_inc     = {state_cur.length_accum[6:0], 3'b000}
                        + {state_cur.length_accum[8:0], 1'b0}
                        + {6'd0, rx_byte[3:0]};
   assign left_dec         = state_cur.bytes_left - 10'd1;
   assign users_dec        = state_cur.users_left - 7'd1;
   assign users_from_count = accum_inc[6:0];

   always_comb begin
      state_nxt = state_cur;
      kind      = KIND_TYPE;
      ftype     = state_cur.frame_code;
      flast     = 1'b0;
      fend      = 1'b0;

      case (state_cur.parse_phase)
         PH_SNDLEN, PH_MSGLEN, PH_USERCOUNT, PH_NAMELEN: begin
            if (!is_digit) begin
               kind                  = KIND_BADDIG;
               flast                 = 1'b1;
               fend                  = 1'b1;
               state_nxt.parse_phase = PH_WAIT;
            end else begin
               kind                   = KIND_DIGIT;
               state_nxt.length_accum = accum_inc;
               state_nxt.digit_count  = count_inc;
               if (count_inc >= digits_needed) begin
                  flast = 1'b1;
                  case (state_cur.parse_phase)
                     PH_SNDLEN: begin
                        if (accum_inc == 10'd0) begin
                           // empty sender: go straight to message length
                           state_nxt.parse_phase  = PH_MSGLEN;
                           state_nxt.digit_count  = 2'd0;
                           state_nxt.length_accum = 10'd0;
                        end else begin
                           state_nxt.bytes_left  = accum_inc;
                           state_nxt.parse_phase = PH_SENDER;
                        end
                     end
                     PH_MSGLEN: begin
                        if (accum_inc == 10'd0) begin
                           fend                  = 1'b1;
                           state_nxt.parse_phase = PH_WAIT;
                        end else begin
                           state_nxt.bytes_left  = accum_inc;
                           state_nxt.parse_phase = PH_MESSAGE;
                        end
                     end
                     PH_USERCOUNT: begin
                        state_nxt.users_left = users_from_count;
                        if (users_from_count == 7'd0) begin
                           fend                  = 1'b1;
                           state_nxt.parse_phase = PH_WAIT;
                        end else begin
                           state_nxt.parse_phase  = PH_NAMELEN;
                           state_nxt.digit_count  = 2'd0;
                           state_nxt.length_accum = 10'd0;
                        end
                     end
                     default: begin
                        state_nxt.users_left = users_dec;
                        if (accum_inc != 10'd0) begin
                           state_nxt.bytes_left  = accum_inc;
                           state_nxt.parse_phase = PH_NAME;
                        end else if (users_dec == 7'd0) begin
                           fend                  = 1'b1;
                           state_nxt.parse_phase = PH_WAIT;
                        end else begin
                           state_nxt.parse_phase  = PH_NAMELEN;
                           state_nxt.digit_count  = 2'd0;
                           state_nxt.length_accum = 10'd0;
                        end
                     end
                  endcase
               end
            end
         end
         PH_SENDER, PH_MESSAGE, PH_ERRTEXT, PH_NAME: begin
            case (state_cur.parse_phase)
               PH_SENDER:  kind = KIND_SENDER;
               PH_MESSAGE: kind = KIND_MESSAGE;
               PH_ERRTEXT: kind = KIND_ERRTEXT;
               default:    kind = KIND_NAME;
            endcase
            state_nxt.bytes_left = left_dec;
            if (left_dec == 10'd0) begin
               flast = 1'b1;
               if (state_cur.parse_phase == PH_SENDER) begin
                  state_nxt.parse_phase  = PH_MSGLEN;
                  state_nxt.digit_count  = 2'd0;
                  state_nxt.length_accum = 10'd0;
               end else if (state_cur.parse_phase == PH_NAME &&
                            state_cur.users_left != 7'd0) begin
                  state_nxt.parse_phase  = PH_NAMELEN;
                  state_nxt.digit_count  = 2'd0;
                  state_nxt.length_accum = 10'd0;
               end else begin
                  fend                  = 1'b1;
                  state_nxt.parse_phase = PH_WAIT;
               end
            end
         end
         default: begin
            // waiting for a type byte; unused phase codes land here too
            state_nxt.parse_phase = PH_WAIT;
            flast                 = 1'b1;
            if (rx_byte inside {CHAR_PRIVATE, CHAR_BROADCAST}) begin
               state_nxt.frame_code   = (rx_byte == CHAR_PRIVATE) ? FRAME_PRIVATE
                                                                  : FRAME_BROADCAST;
               state_nxt.parse_phase  = PH_SNDLEN;
               state_nxt.digit_count  = 2'd0;
               state_nxt.length_accum = 10'd0;
               ftype                  = state_nxt.frame_code;
            end else if (rx_byte == CHAR_ERROR) begin
               state_nxt.frame_code = FRAME_ERROR;
               ftype                = FRAME_ERROR;
               if (error_text_length == 8'd0) begin
                  fend = 1'b1;
               end else begin
                  state_nxt.bytes_left  = {2'b00, error_text_length};
                  state_nxt.parse_phase = PH_ERRTEXT;
               end
            end else if (rx_byte == CHAR_USERLIST) begin
               state_nxt.frame_code   = FRAME_USERLIST;
               ftype                  = FRAME_USERLIST;
               state_nxt.parse_phase  = PH_USERCOUNT;
               state_nxt.digit_count  = 2'd0;
               state_nxt.length_accum = 10'd0;
            end else begin
               kind  = KIND_UNKNOWN;
               fend  = 1'b1;
               ftype = FRAME_PRIVATE;
            end
         end
      endcase

      result.byte_value = rx_byte;
      result.byte_kind  = kind;
      result.frame_type = ftype;
      result.field_last = flast;
      result.frame_end  = fend;
   end

endmodule
`default_nettype wire

FILE: src/decimal_length_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_length_frame_parser
// Tags each received byte of a chat stream by field and frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one received byte per item (req_valid / req_stall).
//   rsp_ channel: one tag item per byte, in order (rsp_valid / rsp_stall):
//     the byte, its kind, the frame type and last-of-field / end-of-frame.
//   csr_ port: csr_wr_en writes csr_wr_data as the error text length;
//     write only while no byte is in flight.
//   The input register feeds the tag logic, which loads the result register.
//   Throughput is 1 byte per cycle while rsp_stall is low; the parse state
//   updates in the same cycle the tag is computed, so bytes may follow
//   back to back.
//   req_stall rises only when both the input and result registers hold an
//   item and rsp_stall is high; items are held, never dropped.
//   Reset (synchronous, active high) empties both registers, sets the
//   parser to wait for a type byte and the error text length to 15.
// ----------------------------------------------------------------------------
module decimal_length_frame_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_byte_value,
   output logic [2:0]      rsp_byte_kind,
   output logic [1:0]      rsp_frame_type,
   output logic            rsp_field_last,
   output logic            rsp_frame_end,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);
   import dlfp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   state_type  state_ff, state_in;
   result_type step_result;
   logic [7:0] err_len_ff;
   logic       out_free;
   logic       advance;
   logic       req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   dlfp_step u_step (
      .rx_byte           (in_byte_ff),
      .error_text_length (err_len_ff),
      .state_cur         (state_ff),
      .state_nxt         (state_in),
      .result            (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         err_len_ff   <= ERROR_LEN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // commit the parse state only when the item moves on
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            err_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_value = out_ff.byte_value;
   assign rsp_byte_kind  = out_ff.byte_kind;
   assign rsp_frame_type = out_ff.frame_type;
   assign rsp_field_last = out_ff.field_last;
   assign rsp_frame_end  = out_ff.frame_end;

endmodule
`default_nettype wire

FILE: dv/decimal_length_frame_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_length_frame_parser_test
// Streams chat frames (private, broadcast, error, user list) through the byte
// tagger under random idle and stall, predicts every tag in a scoreboard and
// compares the tags field by field in arrival order.
// ----------------------------------------------------------------------------
module decimal_length_frame_parser_test;
   import dlfp_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PHASE_BYTES    = 180;

   class frame_tag_scoreboard;
      logic [7:0] error_length;
      logic [3:0] phase;
      logic [1:0] digits_seen;
      logic [9:0] length_sum;
      logic [9:0] body_left;
      logic [1:0] frame_kind;
      logic [6:0] users_pending;
      result_type tags_due[$];
      int         tags_seen;
      int         mismatches;

      function new();
         error_length  = ERROR_LEN_RESET;
         phase         = PH_WAIT;
         digits_seen   = '0;
         length_sum    = '0;
         body_left     = '0;
         frame_kind    = FRAME_PRIVATE;
         users_pending = '0;
         tags_seen     = 0;
         mismatches    = 0;
      endfunction

      function int pending();
         return tags_due.size();
      endfunction

      function void open_length(logic [3:0] next_phase);
         phase       = next_phase;
         digits_seen = '0;
         length_sum  = '0;
      endfunction

      // go on with the next user entry, or close the frame when none is left
      function bit next_user();
         if (users_pending == 0) begin
            phase = PH_WAIT;
            return 1'b1;
         end
         open_length(PH_NAMELEN);
         return 1'b0;
      endfunction

      function result_type tag_byte(logic [7:0] b);
         result_type t;
         logic [1:0] need;
         t.byte_value = b;
         t.byte_kind  = KIND_TYPE;
         t.frame_type = frame_kind;
         t.field_last = 1'b0;
         t.frame_end  = 1'b0;
         case (phase)
            PH_SNDLEN, PH_MSGLEN, PH_USERCOUNT, PH_NAMELEN: begin
               need = (phase == PH_MSGLEN) ? MSG_LEN_DIGITS : SHORT_LEN_DIGITS;
               if (b < CHAR_ZERO || b > CHAR_NINE) begin
                  t.byte_kind  = KIND_BADDIG;
                  t.field_last = 1'b1;
                  t.frame_end  = 1'b1;
                  phase        = PH_WAIT;
               end else begin
                  t.byte_kind = KIND_DIGIT;
                  length_sum  = 10'(length_sum * 10 + (b - CHAR_ZERO));
                  digits_seen = digits_seen + 2'd1;
                  if (digits_seen >= need) begin
                     t.field_last = 1'b1;
                     case (phase)
                        PH_SNDLEN: begin
                           if (length_sum == 0) begin
                              open_length(PH_MSGLEN);
                           end else begin
                              body_left = length_sum;
                              phase     = PH_SENDER;
                           end
                        end
                        PH_MSGLEN: begin
                           if (length_sum == 0) begin
                              t.frame_end = 1'b1;
                              phase       = PH_WAIT;
                           end else begin
                              body_left = length_sum;
                              phase     = PH_MESSAGE;
                           end
                        end
                        PH_USERCOUNT: begin
                           users_pending = length_sum[6:0];
                           t.frame_end   = next_user();
                        end
                        default: begin
                           users_pending = users_pending - 7'd1;
                           if (length_sum == 0) begin
                              t.frame_end = next_user();
                           end else begin
                              body_left = length_sum;
                              phase     = PH_NAME;
                           end
                        end
                     endcase
                  end
               end
            end
            PH_SENDER, PH_MESSAGE, PH_ERRTEXT, PH_NAME: begin
               t.byte_kind = (phase == PH_SENDER)  ? KIND_SENDER :
                             (phase == PH_MESSAGE) ? KIND_MESSAGE :
                             (phase == PH_ERRTEXT) ? KIND_ERRTEXT : KIND_NAME;
               body_left = body_left - 10'd1;
               if (body_left == 0) begin
                  t.field_last = 1'b1;
                  case (phase)
                     PH_SENDER: open_length(PH_MSGLEN);
                     PH_NAME:   t.frame_end = next_user();
                     default: begin
                        t.frame_end = 1'b1;
                        phase       = PH_WAIT;
                     end
                  endcase
               end
            end
            default: begin
               t.field_last = 1'b1;
               phase        = PH_WAIT;
               case (b)
                  CHAR_PRIVATE, CHAR_BROADCAST: begin
                     frame_kind = (b == CHAR_PRIVATE) ? FRAME_PRIVATE : FRAME_BROADCAST;
                     open_length(PH_SNDLEN);
                  end
                  CHAR_ERROR: begin
                     frame_kind = FRAME_ERROR;
                     if (error_length == 0) begin
                        t.frame_end = 1'b1;
                     end else begin
                        body_left = 10'(error_length);
                        phase     = PH_ERRTEXT;
                     end
                  end
                  CHAR_USERLIST: begin
                     frame_kind = FRAME_USERLIST;
                     open_length(PH_USERCOUNT);
                  end
                  default: begin
                     t.byte_kind = KIND_UNKNOWN;
                     t.frame_end = 1'b1;
                  end
               endcase
               // an unknown type byte leaves the frame code alone but reports private
               t.frame_type = (t.byte_kind == KIND_UNKNOWN) ? FRAME_PRIVATE : frame_kind;
            end
         endcase
         return t;
      endfunction

      function void note_byte(logic [7:0] b);
         tags_due.push_back(tag_byte(b));
      endfunction

      task report(string msg);
         $display("tag %0d: %s", tags_seen, msg);
         mismatches++;
      endtask

      task check_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("%s got %0h, want %0h", name, got, want));
      endtask

      task check_tag(result_type got);
         result_type want;
         if (tags_due.size() == 0) begin
            report($sformatf("unexpected tag for byte %0h", got.byte_value));
         end else begin
            want = tags_due.pop_front();
            check_field("byte_value", got.byte_value, want.byte_value);
            check_field("byte_kind", 8'(got.byte_kind), 8'(want.byte_kind));
            check_field("frame_type", 8'(got.frame_type), 8'(want.frame_type));
            check_field("field_last", 8'(got.field_last), 8'(want.field_last));
            check_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
         end
         tags_seen++;
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_byte_value;
   logic [2:0] rsp_byte_kind;
   logic [1:0] rsp_frame_type;
   logic       rsp_field_last;
   logic       rsp_frame_end;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   frame_tag_scoreboard tag_check = new();
   logic [7:0] byte_q[$];
   bit         spoil_frame;
   int         send_calm = 0;
   int         idle_cycles;

   decimal_length_frame_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_value (rsp_byte_value),
      .rsp_byte_kind  (rsp_byte_kind),
      .rsp_frame_type (rsp_frame_type),
      .rsp_field_last (rsp_field_last),
      .rsp_frame_end  (rsp_frame_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tag_check.note_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall)
            tag_check.check_tag({rsp_byte_value, rsp_byte_kind, rsp_frame_type,
                                 rsp_field_last, rsp_frame_end});
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // result side: short runs of random stall, now and then a long quiet stretch
   initial begin
      int r;
      int span;
      rsp_stall = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         span = (r < 4) ? $urandom_range(40, 200) : $urandom_range(1, 6);
         repeat (span) @(negedge clock);
         rsp_stall <= 1'b1;
         r = $urandom_range(0, 99);
         span = (r < 85) ? $urandom_range(1, 3) :
                (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 40);
         repeat (span) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   function automatic int sender_gap();
      int r;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3)
         send_calm = $urandom_range(20, 80);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] non_digit();
      logic [7:0] b;
      b = 8'($urandom_range(0, 245));
      if (b >= CHAR_ZERO)
         b = b + 8'd10;
      return b;
   endfunction

   // push a decimal length; in a spoiled frame a digit may turn into garbage
   function automatic bit push_length(int value, int ndigits);
      int scale;
      scale = (ndigits == 3) ? 100 : 10;
      for (int k = 0; k < ndigits; k++) begin
         if (spoil_frame && $urandom_range(0, 2) == 0) begin
            byte_q.push_back(non_digit());
            return 1'b1;
         end
         byte_q.push_back(CHAR_ZERO + 8'((value / scale) % 10));
         scale = scale / 10;
      end
      return 1'b0;
   endfunction

   function automatic void push_body(int count);
      repeat (count) byte_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic int pick_len(int usual, int top);
      return ($urandom_range(0, 99) < 85) ? $urandom_range(0, usual) : $urandom_range(0, top);
   endfunction

   function automatic void add_chat_frame(logic [7:0] type_char);
      int sender_len;
      int msg_len;
      int r;
      byte_q.push_back(type_char);
      sender_len = pick_len(12, 99);
      if (push_length(sender_len, 2))
         return;
      push_body(sender_len);
      r = $urandom_range(0, 99);
      msg_len = (r < 2)  ? $urandom_range(0, 999) :
                (r < 12) ? $urandom_range(0, 150) : $urandom_range(0, 30);
      if (push_length(msg_len, 3))
         return;
      push_body(msg_len);
   endfunction

   function automatic void add_user_list();
      int users;
      int name_len;
      byte_q.push_back(CHAR_USERLIST);
      users = pick_len(4, 99);
      if (push_length(users, 2))
         return;
      repeat (users) begin
         name_len = (users > 10) ? $urandom_range(0, 3) : pick_len(8, 99);
         if (push_length(name_len, 2))
            return;
         push_body(name_len);
      end
   endfunction

   function automatic void add_random_frames(int target);
      int r;
      logic [7:0] b;
      while (byte_q.size() < target) begin
         spoil_frame = ($urandom_range(0, 99) < 10);
         r = $urandom_range(0, 99);
         if (r < 10) begin
            do b = 8'($urandom_range(0, 255));
            while (b == CHAR_PRIVATE || b == CHAR_BROADCAST || b == CHAR_ERROR ||
                   b == CHAR_USERLIST);
            byte_q.push_back(b);
         end else if (r < 35) begin
            add_chat_frame(CHAR_PRIVATE);
         end else if (r < 60) begin
            add_chat_frame(CHAR_BROADCAST);
         end else if (r < 75) begin
            byte_q.push_back(CHAR_ERROR);
            push_body(int'(tag_check.error_length));
         end else begin
            add_user_list();
         end
      end
   endfunction

   // hold each byte until accepted; a zero gap keeps valid high into the next item
   task automatic send_queue();
      int gap;
      while (byte_q.size() != 0) begin
         @(negedge clock);
         gap = sender_gap();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid   <= 1'b1;
         req_rx_byte <= byte_q.pop_front();
         do @(posedge clock); while (req_stall);
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic set_error_length(logic [7:0] value);
      while (tag_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tag_check.error_length = value;
   endtask

   initial begin
      logic [7:0] error_lengths[6];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      error_lengths = '{8'd15, 8'd255, 8'd3, 8'd0, 8'd1, 8'd0};
      error_lengths[5] = 8'($urandom_range(2, 254));
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unknown types at both extremes, empty sender and message, bad digits
      // just below and above the digit range, empty user list, final user
      // with an empty name
      byte_q = {8'h00, 8'hFF,
                CHAR_PRIVATE, CHAR_ZERO, CHAR_ZERO, CHAR_ZERO, CHAR_ZERO, CHAR_ZERO,
                CHAR_BROADCAST, CHAR_ZERO, CHAR_ZERO - 8'd1,
                CHAR_USERLIST, CHAR_ZERO, CHAR_ZERO,
                CHAR_USERLIST, CHAR_ZERO, CHAR_ZERO + 8'd1, CHAR_ZERO, CHAR_ZERO,
                CHAR_PRIVATE, CHAR_NINE, CHAR_NINE + 8'd1};
      send_queue();
      // zero text length: the type byte closes the error frame alone
      set_error_length(8'd0);
      byte_q = {CHAR_ERROR};
      send_queue();
      set_error_length(8'd1);
      byte_q = {CHAR_ERROR, 8'hA5};
      send_queue();

      foreach (error_lengths[i]) begin
         set_error_length(error_lengths[i]);
         add_random_frames(PHASE_BYTES);
         send_queue();
      end

      while (tag_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tag_check.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
src/dlfp_pkg.sv
src/dlfp_step.sv
src/decimal_length_frame_parser.sv
dv/decimal_length_frame_parser_test.sv
